### rtl/tbad_pkg.sv
// shared types, codes and constants of the trackball motion shaper
package tbad_pkg;

    // field widths
    localparam int MotionWidth = 8;
    localparam int KeyWidth    = 3;
    localparam int TimeWidth   = 16;
    localparam int ThreshWidth = 7;
    localparam int TapWidth    = 4;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 16;
    localparam int InDataWidth  = 40;
    localparam int OutDataWidth = 24;

    // shaped motion saturates at this magnitude
    localparam logic [6:0] HidMax = 7'd127;
    // raw magnitudes at or above this always saturate
    localparam logic [7:0] ShapeSatMag = 8'd19;
    // reciprocal of three for a square below 2048: q = (sq * 683) >> 11
    localparam logic [9:0] RecipThree = 10'd683;
    localparam int RecipShift = 11;
    // asymmetric offset applied to the secondary axis threshold
    localparam logic signed [9:0] ThreshOffset = 10'sd10;

    // reset values of the configuration registers
    localparam logic [ThreshWidth-1:0] ScrollReset = 7'd40;
    localparam logic [ThreshWidth-1:0] CaretReset  = 7'd50;
    localparam logic [TimeWidth-1:0]   IdleReset   = 16'd500;
    localparam logic [TimeWidth-1:0]   TapReset    = 16'd200;

    // item kind
    typedef enum logic {
        CMD_MOTION = 1'b0,
        CMD_KEY    = 1'b1
    } cmd_t;

    // key identifiers
    typedef enum logic [KeyWidth-1:0] {
        KEY_OTHER     = 3'd0,
        KEY_BUTTON1   = 3'd1,
        KEY_MOUSE_OFF = 3'd2,
        KEY_DRAG      = 3'd3,
        KEY_CARET     = 3'd4,
        KEY_LOCK      = 3'd5,
        KEY_ALT       = 3'd6
    } key_t;

    // tap codes
    typedef enum logic [TapWidth-1:0] {
        TAP_NONE        = 4'd0,
        TAP_WHEEL_DOWN  = 4'd1,
        TAP_WHEEL_UP    = 4'd2,
        TAP_WHEEL_RIGHT = 4'd3,
        TAP_WHEEL_LEFT  = 4'd4,
        TAP_ARROW_RIGHT = 4'd5,
        TAP_ARROW_LEFT  = 4'd6,
        TAP_ARROW_DOWN  = 4'd7,
        TAP_ARROW_UP    = 4'd8
    } tap_t;

    // configuration register indexes
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SCROLL_THRESH = 2'd0,
        CFG_CARET_THRESH  = 2'd1,
        CFG_IDLE_TIMEOUT  = 2'd2,
        CFG_TAP_WINDOW    = 2'd3
    } cfg_idx_t;

    // one input item
    typedef struct packed {
        cmd_t                          cmd;
        logic signed [MotionWidth-1:0] motion_x;
        logic signed [MotionWidth-1:0] motion_y;
        logic [KeyWidth-1:0]           key_id;
        logic                          pressed;
        logic [TimeWidth-1:0]          now_ms;
    } item_t;

    // one result item
    typedef struct packed {
        logic signed [MotionWidth-1:0] out_x;
        logic signed [MotionWidth-1:0] out_y;
        tap_t                          tap_event;
        logic                          layer_active;
        logic                          scroll_active;
        logic                          caret_active;
    } result_t;

    // configuration values
    typedef struct packed {
        logic [ThreshWidth-1:0] scroll_threshold;
        logic [ThreshWidth-1:0] caret_threshold;
        logic [TimeWidth-1:0]   idle_timeout_ms;
        logic [TimeWidth-1:0]   tap_window_ms;
    } cfg_t;

endpackage

### rtl/tbad_shape.sv
// acceleration curve v*v/3 + v for one axis, odd-symmetric, clamped to +-127
module tbad_shape (
    input  logic signed [tbad_pkg::MotionWidth-1:0] raw,
    output logic signed [tbad_pkg::MotionWidth-1:0] shaped
);
    import tbad_pkg::*;

    logic [7:0]  mag;
    logic [4:0]  small_mag;
    logic [9:0]  square;
    logic [19:0] prod;
    logic [6:0]  quot;
    logic [6:0]  res_mag;

    // magnitude of the raw delta, -128 gives 128
    assign mag       = raw[7] ? (8'd0 - raw) : raw;
    assign small_mag = mag[4:0];

    // square and divide by three through the reciprocal
    always_comb
    begin
        square = {5'd0, small_mag} * {5'd0, small_mag};
        prod   = {10'd0, square} * {10'd0, RecipThree};
        quot   = prod[RecipShift +: 7];
        if (mag >= ShapeSatMag)
        begin
            res_mag = HidMax;
        end
        else
        begin
            res_mag = quot + {2'd0, small_mag};
        end
    end

    // restore the sign
    assign shaped = raw[7] ? (8'd0 - {1'b0, res_mag}) : {1'b0, res_mag};

endmodule

### rtl/tbad_core.sv
// mode, lock and layer state, accumulators and per-item result logic
module tbad_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tbad_pkg::item_t   item,
    input  tbad_pkg::cfg_t    cfg,
    output tbad_pkg::result_t result
);
    import tbad_pkg::*;

    logic scroll_mode_reg, scroll_mode_next;
    logic caret_mode_reg, caret_mode_next;
    logic lock_flag_reg, lock_flag_next;
    logic lock_latched_reg, lock_latched_next;
    logic layer_flag_reg, layer_flag_next;
    logic scroll_before_reg, scroll_before_next;
    logic caret_before_reg, caret_before_next;
    logic [TimeWidth-1:0] last_motion_reg, last_motion_next;
    logic [TimeWidth-1:0] press_time_reg, press_time_next;
    logic [MotionWidth-1:0] accum_x_reg, accum_x_next;
    logic [MotionWidth-1:0] accum_y_reg, accum_y_next;

    logic signed [MotionWidth-1:0] shaped_x;
    logic signed [MotionWidth-1:0] shaped_y;
    logic [MotionWidth-1:0] sum_x;
    logic [MotionWidth-1:0] sum_y;
    logic signed [9:0] ax;
    logic signed [9:0] ay;
    logic signed [9:0] s_thr;
    logic signed [9:0] c_thr;
    logic [TimeWidth-1:0] idle_elapsed;
    logic [TimeWidth-1:0] press_elapsed;
    logic tap_short;
    tap_t tap;

    // shaping of both axes
    tbad_shape u_shape_x (
        .raw    (item.motion_x),
        .shaped (shaped_x)
    );

    tbad_shape u_shape_y (
        .raw    (item.motion_y),
        .shaped (shaped_y)
    );

    // elapsed times and accumulator sums
    assign idle_elapsed  = item.now_ms - last_motion_reg;
    assign press_elapsed = item.now_ms - press_time_reg;
    assign tap_short     = press_elapsed < cfg.tap_window_ms;
    assign sum_x = accum_x_reg + shaped_x;
    assign sum_y = accum_y_reg + shaped_y;
    assign ax    = {{2{sum_x[7]}}, sum_x};
    assign ay    = {{2{sum_y[7]}}, sum_y};
    assign s_thr = {3'd0, cfg.scroll_threshold};
    assign c_thr = {3'd0, cfg.caret_threshold};

    // tap code from the updated accumulators
    always_comb
    begin
        tap = TAP_NONE;
        if (scroll_mode_reg)
        begin
            if (ay > s_thr)
            begin
                tap = TAP_WHEEL_DOWN;
            end
            else if (ay < -s_thr)
            begin
                tap = TAP_WHEEL_UP;
            end
            else if (ax > s_thr - ThreshOffset)
            begin
                tap = TAP_WHEEL_RIGHT;
            end
            else if (ax < -s_thr - ThreshOffset)
            begin
                tap = TAP_WHEEL_LEFT;
            end
        end
        else if (caret_mode_reg)
        begin
            if (ax > c_thr)
            begin
                tap = TAP_ARROW_RIGHT;
            end
            else if (ax < -c_thr)
            begin
                tap = TAP_ARROW_LEFT;
            end
            else if (ay > c_thr + ThreshOffset)
            begin
                tap = TAP_ARROW_DOWN;
            end
            else if (ay < -c_thr + ThreshOffset)
            begin
                tap = TAP_ARROW_UP;
            end
        end
    end

    // next state and result
    always_comb
    begin
        scroll_mode_next   = scroll_mode_reg;
        caret_mode_next    = caret_mode_reg;
        lock_flag_next     = lock_flag_reg;
        lock_latched_next  = lock_latched_reg;
        layer_flag_next    = layer_flag_reg;
        scroll_before_next = scroll_before_reg;
        caret_before_next  = caret_before_reg;
        last_motion_next   = last_motion_reg;
        press_time_next    = press_time_reg;
        accum_x_next       = accum_x_reg;
        accum_y_next       = accum_y_reg;
        result.out_x       = '0;
        result.out_y       = '0;
        result.tap_event   = TAP_NONE;

        if (item.cmd == CMD_KEY)
        begin
            unique case (item.key_id)
                KEY_BUTTON1:
                begin
                    if (item.pressed)
                    begin
                        last_motion_next = item.now_ms;
                        scroll_mode_next = 1'b0;
                        caret_mode_next  = 1'b0;
                        lock_flag_next   = 1'b1;
                    end
                    else if (!lock_latched_reg)
                    begin
                        lock_flag_next = 1'b0;
                    end
                end
                KEY_MOUSE_OFF:
                begin
                    if (item.pressed)
                    begin
                        layer_flag_next  = 1'b0;
                        scroll_mode_next = 1'b0;
                        caret_mode_next  = 1'b0;
                        lock_flag_next   = 1'b0;
                    end
                end
                KEY_DRAG:
                begin
                    if (item.pressed)
                    begin
                        press_time_next    = item.now_ms;
                        scroll_before_next = scroll_mode_reg;
                        scroll_mode_next   = 1'b1;
                        if (!lock_latched_reg)
                        begin
                            lock_flag_next = !lock_flag_reg;
                        end
                    end
                    else if (tap_short)
                    begin
                        scroll_mode_next = !scroll_before_reg;
                    end
                    else
                    begin
                        if (!lock_latched_reg)
                        begin
                            lock_flag_next = 1'b0;
                        end
                        scroll_mode_next = 1'b0;
                    end
                end
                KEY_CARET:
                begin
                    if (item.pressed)
                    begin
                        press_time_next   = item.now_ms;
                        caret_before_next = caret_mode_reg;
                        caret_mode_next   = 1'b1;
                    end
                    else if (tap_short)
                    begin
                        caret_mode_next = !caret_before_reg;
                    end
                    else
                    begin
                        caret_mode_next = 1'b0;
                    end
                end
                KEY_LOCK:
                begin
                    if (item.pressed)
                    begin
                        lock_flag_next    = !lock_flag_reg;
                        lock_latched_next = !lock_latched_reg;
                    end
                end
                KEY_ALT:
                begin
                    caret_mode_next = item.pressed;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // layer on with motion, off after the idle period unless the lock flag is set
            if ((item.motion_x != '0) || (item.motion_y != '0))
            begin
                layer_flag_next  = 1'b1;
                last_motion_next = item.now_ms;
            end
            else if ((idle_elapsed > cfg.idle_timeout_ms) && layer_flag_reg && !lock_flag_reg)
            begin
                layer_flag_next = 1'b0;
            end

            if (scroll_mode_reg || caret_mode_reg)
            begin
                if (scroll_mode_reg)
                begin
                    caret_mode_next = 1'b0;
                end
                result.tap_event = tap;
                if (tap != TAP_NONE)
                begin
                    accum_x_next = '0;
                    accum_y_next = '0;
                end
                else
                begin
                    accum_x_next = sum_x;
                    accum_y_next = sum_y;
                end
            end
            else
            begin
                result.out_x = shaped_x;
                result.out_y = shaped_y;
            end
        end

        result.layer_active  = layer_flag_next;
        result.scroll_active = scroll_mode_next;
        result.caret_active  = caret_mode_next;
    end

    // state registers, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_mode_reg   <= 1'b0;
            caret_mode_reg    <= 1'b0;
            lock_flag_reg     <= 1'b0;
            lock_latched_reg  <= 1'b0;
            layer_flag_reg    <= 1'b0;
            scroll_before_reg <= 1'b0;
            caret_before_reg  <= 1'b0;
            last_motion_reg   <= '0;
            press_time_reg    <= '0;
            accum_x_reg       <= '0;
            accum_y_reg       <= '0;
        end
        else if (step)
        begin
            scroll_mode_reg   <= scroll_mode_next;
            caret_mode_reg    <= caret_mode_next;
            lock_flag_reg     <= lock_flag_next;
            lock_latched_reg  <= lock_latched_next;
            layer_flag_reg    <= layer_flag_next;
            scroll_before_reg <= scroll_before_next;
            caret_before_reg  <= caret_before_next;
            last_motion_reg   <= last_motion_next;
            press_time_reg    <= press_time_next;
            accum_x_reg       <= accum_x_next;
            accum_y_reg       <= accum_y_next;
        end
    end

endmodule

### rtl/trackball_accel_dragscroll.sv
// top level: stream ports, configuration registers, input and result registers
//
// Trackball motion shaper with drag-scroll and caret modes. Each input
// transaction (a motion report or a key event with its millisecond stamp)
// gives exactly one output transaction. An item is captured in the input
// register, processed by combinational logic against the mode state, and
// lands in the result register, so the block takes one item every cycle
// while the receiver does not stall, and each result passes through the
// input and result registers before it leaves. The configuration channel
// is always ready and must only be written while no item is in flight.
module trackball_accel_dragscroll (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // motion_x[7:0], motion_y[15:8], key_id[18:16], pressed[19], now_ms[35:20], zero
    input  logic [tbad_pkg::InDataWidth-1:0]     s_tdata,
    // cmd[0]
    input  logic                                 s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x[7:0], out_y[15:8], tap_event[19:16], layer_active[20],
    // scroll_active[21], caret_active[22], zero[23]
    output logic [tbad_pkg::OutDataWidth-1:0]    m_tdata,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tbad_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [tbad_pkg::CfgDataWidth-1:0]    cfg_data
);
    import tbad_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t result_next;
    item_t   item_next;
    logic    advance;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scroll_threshold <= ScrollReset;
            cfg_reg.caret_threshold  <= CaretReset;
            cfg_reg.idle_timeout_ms  <= IdleReset;
            cfg_reg.tap_window_ms    <= TapReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SCROLL_THRESH: cfg_reg.scroll_threshold <= cfg_data[ThreshWidth-1:0];
                CFG_CARET_THRESH:  cfg_reg.caret_threshold  <= cfg_data[ThreshWidth-1:0];
                CFG_IDLE_TIMEOUT:  cfg_reg.idle_timeout_ms  <= cfg_data[TimeWidth-1:0];
                CFG_TAP_WINDOW:    cfg_reg.tap_window_ms    <= cfg_data[TimeWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake: item moves on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // unpack the incoming transaction
    always_comb
    begin
        item_next.cmd      = cmd_t'(s_tuser);
        item_next.motion_x = s_tdata[7:0];
        item_next.motion_y = s_tdata[15:8];
        item_next.key_id   = s_tdata[18:16];
        item_next.pressed  = s_tdata[19];
        item_next.now_ms   = s_tdata[35:20];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

    // per-item processing and state
    tbad_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // pack the outgoing transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.caret_active,
                       result_reg.scroll_active,
                       result_reg.layer_active,
                       result_reg.tap_event,
                       result_reg.out_y,
                       result_reg.out_x};

endmodule

### tb/trackball_accel_dragscroll_tb.sv
// self-checking testbench for the trackball motion shaper with drag-scroll and caret modes
`timescale 1ns / 1ps

module trackball_accel_dragscroll_tb;

    import tbad_pkg::*;

    localparam int      ClkHalf    = 6;
    localparam int      LongHold   = 400;
    localparam int      IdleLimit  = 3000;
    localparam int      SettlePad  = 8;
    // key code outside the named set, ignored by the block
    localparam logic [KeyWidth-1:0] KeyUnused = 3'd7;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OutDataWidth-1:0] m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    trackball_accel_dragscroll dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predicted state of the shaper
    logic [ThreshWidth-1:0] thr_scroll;
    logic [ThreshWidth-1:0] thr_caret;
    logic [TimeWidth-1:0]   idle_ms;
    logic [TimeWidth-1:0]   window_ms;
    logic                   drag_on;
    logic                   caret_on;
    logic                   lock_on;
    logic                   lock_held;
    logic                   mouse_layer;
    logic                   drag_prev;
    logic                   caret_was;
    logic [TimeWidth-1:0]   last_move_ms;
    logic [TimeWidth-1:0]   key_down_ms;
    logic signed [7:0]      acc_x;
    logic signed [7:0]      acc_y;

    result_t                expected_reports[$];
    int                     fail_count;
    int                     items_sent;
    int                     hold_asks;
    int                     holds_done;
    int                     idle_cycles;
    bit                     steady;
    logic [TimeWidth-1:0]   clock_ms;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #ClkHalf clk = ~clk;
    end

    // acceleration curve: v*v/3 + v with odd symmetry, clamped
    function automatic int accel_curve(int v);
        int sq;
        int r;
        sq = (v * v) / 3;
        r = (v > 0) ? sq + v : v - sq;
        if (r > 127)
            r = 127;
        if (r < -127)
            r = -127;
        return r;
    endfunction

    // key handling: modes, lock and layer flags
    function automatic void apply_key(logic [KeyWidth-1:0] key, logic pr,
                                      logic [TimeWidth-1:0] now);
        case (key)
            KEY_BUTTON1:
            begin
                if (pr)
                begin
                    last_move_ms = now;
                    drag_on = 1'b0;
                    caret_on = 1'b0;
                    lock_on = 1'b1;
                end
                else if (!lock_held)
                    lock_on = 1'b0;
            end
            KEY_MOUSE_OFF:
            begin
                if (pr)
                begin
                    mouse_layer = 1'b0;
                    drag_on = 1'b0;
                    caret_on = 1'b0;
                    lock_on = 1'b0;
                end
            end
            KEY_DRAG:
            begin
                if (pr)
                begin
                    key_down_ms = now;
                    drag_prev = drag_on;
                    drag_on = 1'b1;
                    if (!lock_held)
                        lock_on = !lock_on;
                end
                else if (16'(now - key_down_ms) < window_ms)
                    drag_on = !drag_prev;
                else
                begin
                    if (!lock_held)
                        lock_on = 1'b0;
                    drag_on = 1'b0;
                end
            end
            KEY_CARET:
            begin
                if (pr)
                begin
                    key_down_ms = now;
                    caret_was = caret_on;
                    caret_on = 1'b1;
                end
                else if (16'(now - key_down_ms) < window_ms)
                    caret_on = !caret_was;
                else
                    caret_on = 1'b0;
            end
            KEY_LOCK:
            begin
                if (pr)
                begin
                    lock_on = !lock_on;
                    lock_held = !lock_held;
                end
            end
            KEY_ALT:
                caret_on = pr;
            default:
                ;
        endcase
    endfunction

    // expected report for one item, advancing the predicted state
    function automatic result_t next_report(item_t it);
        result_t r;
        int      rx;
        int      ry;
        int      ox;
        int      oy;
        int      ax;
        int      ay;
        int      lim;
        tap_t    tap;
        ox = 0;
        oy = 0;
        tap = TAP_NONE;
        if (it.cmd == CMD_KEY)
            apply_key(it.key_id, it.pressed, it.now_ms);
        else
        begin
            rx = $signed(it.motion_x);
            ry = $signed(it.motion_y);
            if (rx != 0 || ry != 0)
            begin
                mouse_layer = 1'b1;
                last_move_ms = it.now_ms;
            end
            else if (16'(it.now_ms - last_move_ms) > idle_ms && mouse_layer && !lock_on)
                mouse_layer = 1'b0;
            ox = accel_curve(rx);
            oy = accel_curve(ry);
            if (drag_on || caret_on)
            begin
                if (drag_on)
                    caret_on = 1'b0;
                acc_x = acc_x + ox[7:0];
                acc_y = acc_y + oy[7:0];
                ox = 0;
                oy = 0;
                ax = acc_x;
                ay = acc_y;
                if (drag_on)
                begin
                    lim = thr_scroll;
                    if (ay > lim)
                        tap = TAP_WHEEL_DOWN;
                    else if (ay < -lim)
                        tap = TAP_WHEEL_UP;
                    else if (ax > lim - 10)
                        tap = TAP_WHEEL_RIGHT;
                    else if (ax < -lim - 10)
                        tap = TAP_WHEEL_LEFT;
                end
                else
                begin
                    lim = thr_caret;
                    if (ax > lim)
                        tap = TAP_ARROW_RIGHT;
                    else if (ax < -lim)
                        tap = TAP_ARROW_LEFT;
                    else if (ay > lim + 10)
                        tap = TAP_ARROW_DOWN;
                    else if (ay < -lim + 10)
                        tap = TAP_ARROW_UP;
                end
                if (tap != TAP_NONE)
                begin
                    acc_x = '0;
                    acc_y = '0;
                end
            end
        end
        r.out_x = ox[7:0];
        r.out_y = oy[7:0];
        r.tap_event = tap;
        r.layer_active = mouse_layer;
        r.scroll_active = drag_on;
        r.caret_active = caret_on;
        return r;
    endfunction

    // stall or gap length: mostly short, a few long
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // timestamp advance; a negative step picks a random one
    function automatic logic [TimeWidth-1:0] stamp(int step);
        int r;
        if (step < 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                step = $urandom_range(0, 40);
            else if (r < 85)
                step = $urandom_range(40, 300);
            else if (r < 95)
                step = $urandom_range(300, 1200);
            else
                step = $urandom_range(0, 65535);
        end
        clock_ms = clock_ms + 16'(step);
        return clock_ms;
    endfunction

    function automatic int rand_motion();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40)
            v = $urandom_range(0, 12);
        else if (r < 70)
            v = $urandom_range(0, 40);
        else if (r < 85)
            return $signed(8'($urandom));
        else if (r < 93)
            return 0;
        else
            return (r < 96) ? -128 : ((r < 98) ? 127 : -127);
        return v - ((r < 40) ? 6 : 20);
    endfunction

    function automatic item_t motion_item(int x, int y, int step);
        item_t it;
        it.cmd = CMD_MOTION;
        it.motion_x = x[7:0];
        it.motion_y = y[7:0];
        it.key_id = 3'($urandom);
        it.pressed = 1'($urandom);
        it.now_ms = stamp(step);
        return it;
    endfunction

    function automatic item_t key_item(logic [KeyWidth-1:0] key, logic pr, int step);
        item_t it;
        it.cmd = CMD_KEY;
        it.motion_x = 8'($urandom);
        it.motion_y = 8'($urandom);
        it.key_id = key;
        it.pressed = pr;
        it.now_ms = stamp(step);
        return it;
    endfunction

    // offer one item, wait for the transaction, then predict its report
    task automatic send_item(input item_t it);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_stall();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {4'b0, it.now_ms, it.pressed, it.key_id, it.motion_y, it.motion_x};
        do
            @(posedge clk);
        while (!s_tready);
        expected_reports.push_back(next_report(it));
        if (!(it.cmd == CMD_KEY && (it.key_id == KEY_OTHER || it.key_id == KeyUnused)))
            items_sent++;
    endtask

    // stop offering and wait until every report has come back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SettlePad) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataWidth-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SCROLL_THRESH: thr_scroll = data[ThreshWidth-1:0];
            CFG_CARET_THRESH:  thr_caret  = data[ThreshWidth-1:0];
            CFG_IDLE_TIMEOUT:  idle_ms    = data;
            CFG_TAP_WINDOW:    window_ms  = data;
            default:           ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random traffic: mode gestures with motion inside them, runs of motion, single keys and idle reports
    task automatic run_random(input int count, input bit back_to_back);
        int             stop_at;
        int             kind;
        int             n;
        logic [KeyWidth-1:0] key;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            steady = back_to_back || ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            n = $urandom_range(0, 12);
            case ($urandom_range(0, 3))
                0:       key = KEY_DRAG;
                1:       key = KEY_CARET;
                2:       key = KEY_ALT;
                default: key = KEY_BUTTON1;
            endcase
            if (kind < 3)
            begin
                // hold the mode key over a run of motion
                send_item(key_item(key, 1'b1, -1));
                repeat (n) send_item(motion_item(rand_motion(), rand_motion(), -1));
                send_item(key_item(key, 1'b0, -1));
            end
            else if (kind < 5)
            begin
                // tap the mode key to toggle, move, tap again
                send_item(key_item(key, 1'b1, $urandom_range(0, 20)));
                send_item(key_item(key, 1'b0, $urandom_range(0, 20)));
                repeat (n) send_item(motion_item(rand_motion(), rand_motion(), -1));
                send_item(key_item(key, 1'b1, $urandom_range(0, 20)));
                send_item(key_item(key, 1'b0, -1));
            end
            else if (kind < 8)
                repeat (n + 1) send_item(motion_item(rand_motion(), rand_motion(), -1));
            else if (kind == 8)
                send_item(key_item(3'($urandom_range(0, 7)), 1'($urandom), -1));
            else
                send_item(motion_item(0, 0, $urandom_range(0, 1500)));
        end
        steady = 1'b0;
    endtask

    // extremes of the acceleration curve and clamp
    task automatic test_shaping();
        send_item(motion_item(18, -19, 3));
        send_item(motion_item(-128, 127, 3));
        send_item(motion_item(127, -128, 3));
    endtask

    // lock latch, button-1 lock, ignored keys and ignored releases
    task automatic test_key_events();
        send_item(key_item(KeyUnused, 1'b1, 2));
        send_item(key_item(KEY_LOCK, 1'b1, 2));
        send_item(key_item(KEY_BUTTON1, 1'b1, 2));
        send_item(key_item(KEY_BUTTON1, 1'b0, 2));
        send_item(key_item(KEY_LOCK, 1'b0, 2));
        send_item(key_item(KEY_LOCK, 1'b1, 2));
        send_item(key_item(KEY_MOUSE_OFF, 1'b0, 2));
    endtask

    // every wheel and arrow tap, and scroll overriding caret
    task automatic test_taps();
        send_item(key_item(KEY_DRAG, 1'b1, 5));
        send_item(key_item(KEY_DRAG, 1'b0, 5));
        send_item(motion_item(0, 127, 5));
        send_item(motion_item(0, -20, 5));
        send_item(motion_item(10, 0, 5));
        send_item(motion_item(-15, 0, 5));
        send_item(key_item(KEY_ALT, 1'b1, 5));
        send_item(motion_item(1, 1, 5));
        send_item(key_item(KEY_MOUSE_OFF, 1'b1, 5));
        send_item(key_item(KEY_ALT, 1'b1, 5));
        send_item(motion_item(12, 0, 5));
        send_item(motion_item(-12, 0, 5));
        send_item(motion_item(0, 13, 5));
        send_item(motion_item(0, -10, 5));
    endtask

    // layer drops after the idle time, but not while locked
    task automatic test_idle_timeout();
        send_item(motion_item(0, 0, 501));
        send_item(motion_item(2, 0, 5));
        send_item(key_item(KEY_BUTTON1, 1'b1, 5));
        send_item(motion_item(0, 0, 2000));
    endtask

    // several register settings, extremes among them, each with random traffic
    task automatic test_config_sweep();
        logic [6:0]  s_list[6];
        logic [6:0]  c_list[6];
        logic [15:0] i_list[6];
        logic [15:0] w_list[6];
        s_list = '{7'd10, 7'd117, 7'd0, 7'd127, 7'($urandom_range(10, 117)), ScrollReset};
        c_list = '{7'd117, 7'd10, 7'd127, 7'd0, 7'($urandom_range(10, 117)), CaretReset};
        i_list = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'($urandom_range(0, 1500)),
                   IdleReset};
        w_list = '{16'hFFFF, 16'd0, 16'd1, 16'($urandom), 16'($urandom_range(0, 600)),
                   TapReset};
        run_random(100, 1'b0);
        for (int k = 0; k < 6; k++)
        begin
            settle();
            // unused upper bits of a threshold write are dropped
            write_reg(CFG_SCROLL_THRESH, {9'($urandom), s_list[k]});
            write_reg(CFG_CARET_THRESH, {9'($urandom), c_list[k]});
            write_reg(CFG_IDLE_TIMEOUT, i_list[k]);
            write_reg(CFG_TAP_WINDOW, w_list[k]);
            run_random(150, 1'b0);
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_asks++;
        run_random(150, 1'b1);
    endtask

    // result sink with random stalls and requested long holds
    initial
    begin : result_sink
        int left;
        m_tready = 1'b0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left > 0)
                left--;
            else if (holds_done != hold_asks)
            begin
                holds_done++;
                m_tready <= 1'b0;
                left = LongHold;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                left = $urandom_range(0, 20);
            end
            else
            begin
                m_tready <= 1'b0;
                left = pick_stall() - 1;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] expv, logic [7:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, expv, actv);
            fail_count++;
        end
    endfunction

    // compare each result transaction with the oldest expected report
    always @(posedge clk)
    begin : report_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result transaction with no expected report: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("out_x", want.out_x, m_tdata[7:0]);
                check_field("out_y", want.out_y, m_tdata[15:8]);
                check_field("tap_event", 8'(want.tap_event), 8'(m_tdata[19:16]));
                check_field("layer_active", 8'(want.layer_active), 8'(m_tdata[20]));
                check_field("scroll_active", 8'(want.scroll_active), 8'(m_tdata[21]));
                check_field("caret_active", 8'(want.caret_active), 8'(m_tdata[22]));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        items_sent = 0;
        hold_asks = 0;
        holds_done = 0;
        idle_cycles = 0;
        steady = 1'b0;
        clock_ms = 16'hFF00;
        thr_scroll = ScrollReset;
        thr_caret = CaretReset;
        idle_ms = IdleReset;
        window_ms = TapReset;
        {drag_on, caret_on, lock_on, lock_held, mouse_layer, drag_prev, caret_was} = '0;
        last_move_ms = '0;
        key_down_ms = '0;
        acc_x = '0;
        acc_y = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_shaping();
        test_key_events();
        test_taps();
        test_idle_timeout();
        test_config_sweep();
        test_backpressure();
        settle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/tbad_pkg.sv
rtl/tbad_shape.sv
rtl/tbad_core.sv
rtl/trackball_accel_dragscroll.sv
tb/trackball_accel_dragscroll_tb.sv
